### rtl/pqr_pkg.sv
// Shared types and constants for the passive quote reconciler.
// Used by every module under rtl; depends on nothing.
package pqr_pkg;

  localparam int unsigned PriceW   = 32;
  localparam int unsigned QtyW     = 24;
  localparam int unsigned CapW     = 31;
  localparam int unsigned MoveW    = 16;
  localparam int unsigned FeeW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  // 2*edge fits in 35 signed bits; times the fee scale it fits in 53
  localparam int unsigned EdgeW = 35;
  localparam int unsigned ProdW = 53;
  localparam logic signed [ProdW-1:0] FeeScale = 53'sd100000;

  localparam logic [PriceW-1:0] PriceMax = '1;

  typedef enum logic [2:0] {
    CfgMinMove  = 3'd0,
    CfgInvCap   = 3'd1,
    CfgQuoteSz  = 3'd2,
    CfgFloor    = 3'd3,
    CfgEdgeEn   = 3'd4,
    CfgFee      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActPlace   = 2'd1,
    ActCancel  = 2'd2,
    ActReplace = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RsnPlaced     = 3'd0,
    RsnReplaced   = 3'd1,
    RsnUnchanged  = 3'd2,
    RsnSuppressed = 3'd3,
    RsnCap        = 3'd4,
    RsnEdge       = 3'd5,
    RsnUnwanted   = 3'd6,
    RsnNoBook     = 3'd7
  } reason_e;

  typedef struct packed {
    logic [MoveW-1:0]  min_move;
    logic [CapW-1:0]   inv_cap;
    logic [QtyW-1:0]   quote_size;
    logic              floor_at_touch;
    logic              edge_en;
    logic [FeeW-1:0]   fee;
  } pqr_cfg_t;

  typedef struct packed {
    logic               retire;
    logic               side;
    logic               want;
    logic [PriceW-1:0]  model_price;
    logic [PriceW-1:0]  bid_top;
    logic               bid_present;
    logic [PriceW-1:0]  ask_top;
    logic               ask_present;
    logic signed [31:0] inventory;
    logic [CapW-1:0]    working_qty;
    logic               order_live;
  } pqr_in_t;

  // Partly classified item inside the front pipeline
  typedef struct packed {
    logic              retire;
    logic              side;
    logic              book_ok;
    logic              want;
    logic              at_cap;
    logic              live;
    logic [PriceW-1:0] price;
  } pqr_pre_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic              retire;
    logic              side;
    logic              book_ok;
    logic              drop;
    reason_e           drop_reason;
    logic              live;
    logic [PriceW-1:0] price;
  } pqr_cls_t;

  typedef struct packed {
    logic              side;
    action_e           action;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    reason_e           reason;
  } pqr_res_t;

endpackage

### rtl/pqr_front.sv
// Front pipeline: target price, inventory cap and fee-edge tests, three stages.
// Depends on pqr_pkg; feeds pqr_fifo.
module pqr_front import pqr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pqr_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pqr_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pqr_cls_t out_o
);

  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  pqr_pre_t a_d, a_q, b_q, c_q;
  logic [PriceW:0] mid2_d, mid2_q;
  logic signed [EdgeW-1:0] te_d, te_q;
  logic [2*PriceW+FeeW-PriceW-1+PriceW-PriceW:0] fp_d, fp_b_q, fp_c_q;
  logic signed [ProdW-1:0] lhs_d, lhs_q;

  logic [PriceW-1:0] p1, p;
  logic signed [33:0] inv_ext, wq_ext, cap_ext;
  logic signed [33:0] long_sum, short_sum;
  logic edge_ok;

  // Ready ripples back through the stages
  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Stage A: target price and cap test
  always_comb begin
    if (!in_i.side) begin
      p1 = (cfg_i.floor_at_touch && in_i.model_price > in_i.bid_top) ? in_i.bid_top
                                                                      : in_i.model_price;
      if (p1 >= in_i.ask_top) begin
        p = (in_i.ask_top == '0) ? '0 : in_i.ask_top - 32'd1;
      end else begin
        p = p1;
      end
    end else begin
      p1 = (cfg_i.floor_at_touch && in_i.model_price < in_i.ask_top) ? in_i.ask_top
                                                                      : in_i.model_price;
      if (p1 <= in_i.bid_top) begin
        p = (in_i.bid_top == PriceMax) ? PriceMax : in_i.bid_top + 32'd1;
      end else begin
        p = p1;
      end
    end

    inv_ext   = {{2{in_i.inventory[31]}}, in_i.inventory};
    wq_ext    = {3'b000, in_i.working_qty};
    cap_ext   = {3'b000, cfg_i.inv_cap};
    long_sum  = inv_ext + wq_ext;
    short_sum = inv_ext - wq_ext;

    a_d.retire  = in_i.retire;
    a_d.side    = in_i.side;
    a_d.book_ok = in_i.bid_present && in_i.ask_present;
    a_d.want    = in_i.want;
    a_d.at_cap  = in_i.side ? (short_sum <= -cap_ext) : (long_sum >= cap_ext);
    a_d.live    = in_i.order_live;
    a_d.price   = p;
    mid2_d      = {1'b0, in_i.bid_top} + {1'b0, in_i.ask_top};
  end

  // Stage B: twice the edge and fee times price
  always_comb begin
    if (!a_q.side) begin
      te_d = $signed({2'b00, mid2_q}) - $signed({2'b00, a_q.price, 1'b0});
    end else begin
      te_d = $signed({2'b00, a_q.price, 1'b0}) - $signed({2'b00, mid2_q});
    end
    fp_d = {{PriceW{1'b0}}, cfg_i.fee} * {{FeeW{1'b0}}, a_q.price};
  end

  // Stage C: scale the edge
  assign lhs_d = $signed({{(ProdW-EdgeW){te_q[EdgeW-1]}}, te_q}) * FeeScale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_q    <= a_d;
      mid2_q <= mid2_d;
    end
    if (b_ready) begin
      b_q    <= a_q;
      te_q   <= te_d;
      fp_b_q <= fp_d;
    end
    if (c_ready) begin
      c_q    <= b_q;
      lhs_q  <= lhs_d;
      fp_c_q <= fp_b_q;
    end
  end

  assign edge_ok = !cfg_i.edge_en ||
                   (lhs_q > $signed({{(ProdW-PriceW-FeeW-1){1'b0}}, fp_c_q, 1'b0}));

  always_comb begin
    out_o.retire      = c_q.retire;
    out_o.side        = c_q.side;
    out_o.book_ok     = c_q.book_ok;
    out_o.live        = c_q.live;
    out_o.price       = c_q.price;
    out_o.drop        = 1'b1;
    out_o.drop_reason = RsnUnwanted;
    if (!c_q.want) begin
      out_o.drop_reason = RsnUnwanted;
    end else if (c_q.at_cap) begin
      out_o.drop_reason = RsnCap;
    end else if (!edge_ok) begin
      out_o.drop_reason = RsnEdge;
    end else begin
      out_o.drop = 1'b0;
    end
  end

  assign out_valid_o = c_valid_q;

endmodule

### rtl/pqr_fifo.sv
// Short queue of classified items between front and back.
// Depends on pqr_pkg.
module pqr_fifo import pqr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pqr_cls_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pqr_cls_t out_o
);

  pqr_cls_t mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   count_q;
  logic push, pop;

  assign in_ready_o  = (count_q != (FifoAw+1)'(FifoDepth));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + FifoAw'(1);
      if (pop)  rptr_q <= rptr_q + FifoAw'(1);
      if (push && !pop) begin
        count_q <= count_q + (FifoAw+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (FifoAw+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_i;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FifoAw+1)'(FifoDepth))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + (FifoAw+1)'(1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[FifoAw-1:0] == FifoAw'(wptr_q - rptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/pqr_back.sv
// Back end: per-side resting quote state, decision and output register.
// Depends on pqr_pkg; takes items from pqr_fifo.
module pqr_back import pqr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pqr_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pqr_cls_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pqr_res_t out_o
);

  logic              resting_q [2];
  logic [PriceW-1:0] rp_q [2];
  logic              out_valid_q;
  pqr_res_t          res_q, res_d;

  logic              pop;
  logic              rest_now, rest_eff, rest_new;
  logic [PriceW-1:0] rp_now, rp_new, mv;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign pop        = in_valid_i && in_ready_o;

  always_comb begin
    rest_now = resting_q[in_i.side];
    rp_now   = rp_q[in_i.side];
    rest_eff = rest_now && in_i.live;
    rest_new = rest_now;
    rp_new   = rp_now;
    mv       = (in_i.price > rp_now) ? in_i.price - rp_now : rp_now - in_i.price;

    res_d.side   = in_i.side;
    res_d.action = ActNone;
    res_d.price  = '0;
    res_d.qty    = '0;
    res_d.reason = RsnNoBook;

    if (in_i.retire) begin
      rest_new = 1'b0;
    end else if (in_i.book_ok) begin
      // drop a stale quote before deciding
      rest_new = rest_eff;
      if (in_i.drop) begin
        res_d.reason = in_i.drop_reason;
        if (rest_eff) begin
          res_d.action = ActCancel;
          rest_new     = 1'b0;
        end
      end else if (!rest_eff) begin
        res_d.action = ActPlace;
        res_d.reason = RsnPlaced;
        res_d.price  = in_i.price;
        res_d.qty    = cfg_i.quote_size;
        rest_new     = 1'b1;
        rp_new       = in_i.price;
      end else if (rp_now == in_i.price) begin
        res_d.reason = RsnUnchanged;
      end else if (mv < {{(PriceW-MoveW){1'b0}}, cfg_i.min_move}) begin
        res_d.reason = RsnSuppressed;
      end else begin
        res_d.action = ActReplace;
        res_d.reason = RsnReplaced;
        res_d.price  = in_i.price;
        res_d.qty    = cfg_i.quote_size;
        rp_new       = in_i.price;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      resting_q[0] <= 1'b0;
      resting_q[1] <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q            <= 1'b1;
        resting_q[in_i.side]   <= rest_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q             <= res_d;
      rp_q[in_i.side]   <= rp_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

`ifndef NO_ASSERTIONS
  a_quote_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action == ActPlace || res_q.action == ActReplace)
    |-> resting_q[res_q.side] && rp_q[res_q.side] == res_q.price)
    else $error("placed quote not recorded");
  a_cancel_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.action == ActCancel |-> !resting_q[res_q.side])
    else $error("cancelled quote still resting");
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action == ActNone || res_q.action == ActCancel)
    |-> res_q.price == '0 && res_q.qty == '0)
    else $error("price or size on a non-quoting result");
`endif

endmodule

### rtl/passive_quote_reconciler_top.sv
// Each item passes front stages A, B and C, the queue and the output register.
// Throughput: one item per cycle while the master side takes results.
// Front pipeline of three stages, four-entry queue, registered output.
// Reset (rst_ni low, asynchronous) clears all quotes and sets registers to defaults.
// Top level: configuration registers, stream packing, front, queue and back.
// Depends on pqr_pkg, pqr_front, pqr_fifo and pqr_back.
module passive_quote_reconciler_top import pqr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // side, want, model_price, bid_top, bid_present, ask_top, ask_present,
  // inventory, working_qty, order_live, zero fill
  input  logic [167:0]        s_axis_tdata,
  // cmd
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // side_out, action, quote_price, quote_qty, reason, zero fill
  output logic [63:0]         m_axis_tdata
);

  pqr_cfg_t cfg_q;
  pqr_in_t  in_item;
  pqr_cls_t front_item, fifo_item;
  pqr_res_t res;
  logic     front_valid, front_ready, fifo_valid, fifo_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_move       <= MoveW'(1);
      cfg_q.inv_cap        <= '0;
      cfg_q.quote_size     <= QtyW'(1);
      cfg_q.floor_at_touch <= 1'b0;
      cfg_q.edge_en        <= 1'b0;
      cfg_q.fee            <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinMove: cfg_q.min_move       <= cfg_data_i[MoveW-1:0];
        CfgInvCap:  cfg_q.inv_cap        <= cfg_data_i[CapW-1:0];
        CfgQuoteSz: cfg_q.quote_size     <= cfg_data_i[QtyW-1:0];
        CfgFloor:   cfg_q.floor_at_touch <= cfg_data_i[0];
        CfgEdgeEn:  cfg_q.edge_en        <= cfg_data_i[0];
        CfgFee:     cfg_q.fee            <= cfg_data_i[FeeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.retire      = s_axis_tuser[0];
    in_item.side        = s_axis_tdata[0];
    in_item.want        = s_axis_tdata[1];
    in_item.model_price = s_axis_tdata[33:2];
    in_item.bid_top     = s_axis_tdata[65:34];
    in_item.bid_present = s_axis_tdata[66];
    in_item.ask_top     = s_axis_tdata[98:67];
    in_item.ask_present = s_axis_tdata[99];
    in_item.inventory   = $signed(s_axis_tdata[131:100]);
    in_item.working_qty = s_axis_tdata[162:132];
    in_item.order_live  = s_axis_tdata[163];
  end

  pqr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (in_item),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front_item)
  );

  pqr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_item),
    .out_valid_o (fifo_valid),
    .out_ready_i (fifo_ready),
    .out_o       (fifo_item)
  );

  pqr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (fifo_valid),
    .in_ready_o  (fifo_ready),
    .in_i        (fifo_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.reason, res.qty, res.price, res.action, res.side};

endmodule

### sim/tb_passive_quote_reconciler_top.sv
// Self-checking bench for passive_quote_reconciler_top: stream driver, result monitor and
// an in-bench quote predictor, run through a directed opening and several register settings.
// Depends on pqr_pkg and the RTL under rtl only.
module tb_passive_quote_reconciler_top;
  import pqr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CycleLimit = 400000;
  localparam longint BpScale    = 100000;

  typedef struct packed {
    bit        cmd;
    bit        side;
    bit        want;
    bit [31:0] model_px;
    bit [31:0] bid_px;
    bit        bid_ok;
    bit [31:0] ask_px;
    bit        ask_ok;
    bit [31:0] inv;
    bit [30:0] working;
    bit        live;
  } quote_req_t;

  typedef struct packed {
    bit        side;
    action_e   act;
    bit [31:0] px;
    bit [23:0] qty;
    reason_e   why;
  } quote_res_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [167:0]        s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;

  passive_quote_reconciler_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of registers and per-side resting quotes
  bit [15:0] min_move_r = 16'd1;
  bit [30:0] inv_cap_r  = '0;
  bit [23:0] size_r     = 24'd1;
  bit        floor_r    = 1'b0;
  bit        edge_en_r  = 1'b0;
  bit [15:0] fee_r      = '0;
  bit        resting [2] = '{1'b0, 1'b0};
  bit [31:0] rest_px [2] = '{32'd0, 32'd0};

  quote_req_t order_feed[$];
  quote_res_t due_quotes[$];
  quote_req_t cur_req;
  bit         in_taken;
  int         feed_gap, sink_gap, idle_pct;
  int         err_count, cycle_count, items_taken, retires_taken, results_seen;
  int         act_seen [4];
  int         settings_used;

  initial forever #10 clk_i = ~clk_i;

  task automatic flag(string what);
    err_count++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  function automatic quote_res_t reconcile(quote_req_t it);
    quote_res_t r;
    bit         s;
    bit         dropped;
    bit [31:0]  px;
    bit [31:0]  gap;
    longint     inv, wq, cap, twice_mid, twice_edge;
    s     = it.side;
    r.side = s;
    r.act  = ActNone;
    r.px   = '0;
    r.qty  = '0;
    r.why  = RsnNoBook;
    if (it.cmd) begin
      resting[s] = 1'b0;
    end else if (it.bid_ok && it.ask_ok) begin
      px = it.model_px;
      if (!s) begin
        if (floor_r && px > it.bid_px) px = it.bid_px;
        if (px >= it.ask_px) px = (it.ask_px == 0) ? 32'd0 : it.ask_px - 1;
      end else begin
        if (floor_r && px < it.ask_px) px = it.ask_px;
        if (px <= it.bid_px) px = (it.bid_px == PriceMax) ? PriceMax : it.bid_px + 1;
      end
      // forget a quote whose order is gone
      if (resting[s] && !it.live) resting[s] = 1'b0;
      inv        = longint'($signed(it.inv));
      wq         = longint'(it.working);
      cap        = longint'(inv_cap_r);
      twice_mid  = longint'(it.bid_px) + longint'(it.ask_px);
      twice_edge = s ? 2 * longint'(px) - twice_mid : twice_mid - 2 * longint'(px);
      dropped    = 1'b1;
      if (!it.want) r.why = RsnUnwanted;
      else if (s ? (inv - wq <= -cap) : (inv + wq >= cap)) r.why = RsnCap;
      else if (edge_en_r && !(twice_edge * BpScale > 2 * longint'(fee_r) * longint'(px)))
        r.why = RsnEdge;
      else dropped = 1'b0;

      if (dropped) begin
        if (resting[s]) begin
          r.act = ActCancel;
          resting[s] = 1'b0;
        end
      end else if (!resting[s]) begin
        r.act = ActPlace;
        r.why = RsnPlaced;
        r.px  = px;
        r.qty = size_r;
        resting[s] = 1'b1;
        rest_px[s] = px;
      end else if (rest_px[s] == px) begin
        r.why = RsnUnchanged;
      end else begin
        gap = (px > rest_px[s]) ? px - rest_px[s] : rest_px[s] - px;
        if (gap < min_move_r) begin
          r.why = RsnSuppressed;
        end else begin
          r.act = ActReplace;
          r.why = RsnReplaced;
          r.px  = px;
          r.qty = size_r;
          rest_px[s] = px;
        end
      end
    end
    return r;
  endfunction

  // Driver: present items and stall the result side, all at the falling edge
  always @(negedge clk_i) begin
    quote_req_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (order_feed.size() != 0 && $urandom_range(1, 100) <= idle_pct) begin
          feed_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else if (order_feed.size() != 0) begin
          nxt = order_feed.pop_front();
          cur_req       <= nxt;
          s_axis_tdata  <= {4'b0, nxt.live, nxt.working, nxt.inv, nxt.ask_ok, nxt.ask_px,
                            nxt.bid_ok, nxt.bid_px, nxt.model_px, nxt.want, nxt.side};
          s_axis_tuser  <= nxt.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
        sink_gap = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: track register writes, predict taken items, check results
  always @(posedge clk_i) begin
    quote_res_t got, exp_res;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgMinMove: min_move_r = cfg_data_i[15:0];
          CfgInvCap:  inv_cap_r  = cfg_data_i[30:0];
          CfgQuoteSz: size_r     = cfg_data_i[23:0];
          CfgFloor:   floor_r    = cfg_data_i[0];
          CfgEdgeEn:  edge_en_r  = cfg_data_i[0];
          CfgFee:     fee_r      = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        if (cur_req.cmd) retires_taken++;
        due_quotes.push_back(reconcile(cur_req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.side = m_axis_tdata[0];
        got.act  = action_e'(m_axis_tdata[2:1]);
        got.px   = m_axis_tdata[34:3];
        got.qty  = m_axis_tdata[58:35];
        got.why  = reason_e'(m_axis_tdata[61:59]);
        results_seen++;
        act_seen[got.act]++;
        if (due_quotes.size() == 0) begin
          flag("result with no item outstanding");
        end else begin
          exp_res = due_quotes.pop_front();
          if (got.side !== exp_res.side)
            flag($sformatf("side got %0d want %0d", got.side, exp_res.side));
          if (got.act !== exp_res.act)
            flag($sformatf("action got %s want %s", got.act.name(), exp_res.act.name()));
          if (got.px !== exp_res.px)
            flag($sformatf("price got %0d want %0d", got.px, exp_res.px));
          if (got.qty !== exp_res.qty)
            flag($sformatf("qty got %0d want %0d", got.qty, exp_res.qty));
          if (got.why !== exp_res.why)
            flag($sformatf("reason got %s want %s", got.why.name(), exp_res.why.name()));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_passive_quote_reconciler_top: errors");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_e idx, bit [30:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(bit [15:0] mm, bit [30:0] cap, bit [23:0] sz, bit fl, bit en,
                          bit [15:0] fee);
    cfg_write(CfgMinMove, 31'(mm));
    cfg_write(CfgInvCap, cap);
    cfg_write(CfgQuoteSz, 31'(sz));
    cfg_write(CfgFloor, 31'(fl));
    cfg_write(CfgEdgeEn, 31'(en));
    cfg_write(CfgFee, 31'(fee));
    settings_used++;
  endtask

  // Wait for every item to be taken and answered, then let the pipeline empty
  task automatic drain_quotes();
    while (order_feed.size() != 0 || s_axis_tvalid || due_quotes.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_req(int cmd, int sd, int want, longint model, longint bb,
                          int bp, longint ba, int ap, longint inv, longint wq,
                          int live);
    quote_req_t it;
    it.cmd      = cmd[0];
    it.side     = sd[0];
    it.want     = want[0];
    it.model_px = model[31:0];
    it.bid_px   = bb[31:0];
    it.bid_ok   = bp[0];
    it.ask_px   = ba[31:0];
    it.ask_ok   = ap[0];
    it.inv      = inv[31:0];
    it.working  = wq[30:0];
    it.live     = live[0];
    order_feed.push_back(it);
  endtask

  // Mostly coherent books drifting around a centre price, with some noise
  task automatic queue_market(int n, longint centre, int width, int inv_span, int wq_span);
    quote_req_t it;
    longint     lo, hi, model;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        it.cmd      = 1'($urandom_range(0, 1));
        it.side     = 1'($urandom_range(0, 1));
        it.want     = 1'($urandom_range(0, 1));
        it.model_px = $urandom;
        it.bid_px   = $urandom;
        it.bid_ok   = 1'($urandom_range(0, 1));
        it.ask_px   = $urandom;
        it.ask_ok   = 1'($urandom_range(0, 1));
        it.inv      = $urandom;
        it.working  = 31'($urandom);
        it.live     = 1'($urandom_range(0, 1));
      end else begin
        centre = centre + longint'($urandom_range(0, 6)) - 3;
        if (centre < 100) centre = 100;
        if (centre > 64'hFFFF_FF00) centre = 64'hFFFF_FF00;
        lo = centre - longint'($urandom_range(0, width));
        hi = lo + 1 + longint'($urandom_range(0, width));
        // locked or crossed book now and then
        if ($urandom_range(0, 19) == 0) hi = lo - longint'($urandom_range(0, 2));
        model = centre + longint'($urandom_range(0, 4 * width)) - 2 * width;
        if (model < 0) model = 0;
        if (model > 64'hFFFF_FFFF) model = 64'hFFFF_FFFF;
        it.cmd      = ($urandom_range(0, 99) < 6);
        it.side     = 1'($urandom_range(0, 1));
        it.want     = ($urandom_range(0, 99) < 90);
        it.model_px = model[31:0];
        it.bid_px   = lo[31:0];
        it.bid_ok   = ($urandom_range(0, 99) < 96);
        it.ask_px   = hi[31:0];
        it.ask_ok   = ($urandom_range(0, 99) < 96);
        it.inv      = int'($urandom_range(0, 2 * inv_span)) - inv_span;
        it.working  = 31'($urandom_range(0, wq_span));
        it.live     = ($urandom_range(0, 99) < 92);
      end
      order_feed.push_back(it);
    end
  endtask

  initial begin
    idle_pct = 20;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: placement life cycle, book gaps, drops and both clamp limits
    set_regs(16'd3, 31'd1000, 24'd5, 1'b0, 1'b0, 16'd0);
    push_req(1, 0, 1, 100, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 1, 100, 99, 0, 105, 1, 0, 0, 1);
    push_req(0, 1, 1, 100, 99, 1, 105, 0, 0, 0, 1);
    push_req(0, 0, 1, 100, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 1, 100, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 1, 101, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 1, 110, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 1, 104, 99, 1, 105, 1, 0, 0, 0);
    push_req(0, 0, 0, 104, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 0, 0, 104, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 1, 1, 200, 99, 1, 105, 1, 0, 0, 1);
    push_req(0, 1, 1, 200, 99, 1, 105, 1, -990, 20, 1);
    push_req(0, 0, 1, 100, 99, 1, 105, 1, 990, 10, 1);
    push_req(0, 0, 1, 5, 0, 1, 0, 1, 0, 0, 1);
    push_req(0, 1, 1, 7, PriceMax, 1, PriceMax, 1, 0, 0, 1);
    push_req(1, 1, 1, 7, PriceMax, 1, PriceMax, 1, 0, 0, 1);
    push_req(0, 1, 1, 7, PriceMax, 1, PriceMax, 1, 0, 0, 1);
    push_req(0, 0, 1, PriceMax, PriceMax, 1, PriceMax, 1, 32'h8000_0000, 31'h7FFF_FFFF, 1);
    push_req(0, 1, 1, 0, 0, 1, 0, 1, 32'h7FFF_FFFF, 0, 1);
    drain_quotes();

    // Directed: floor at the touch and the fee test at the largest fee
    set_regs(16'd1, 31'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
    push_req(0, 0, 1, 200, 100, 1, 300, 1, 0, 0, 1);
    push_req(0, 0, 1, 200, 100, 1, 102, 1, 0, 0, 1);
    push_req(0, 1, 1, 50, 100, 1, 300, 1, 0, 0, 1);
    push_req(0, 1, 1, 5000, 100, 1, 300, 1, 0, 0, 1);
    drain_quotes();

    idle_pct = 25;
    set_regs(16'd0, 31'h7FFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0, 16'd0);
    queue_market(300, 64'hFFFF_FC00, 6, 1000000, 1000);
    drain_quotes();

    idle_pct = 10;
    set_regs(16'hFFFF, 31'd0, 24'd0, 1'b1, 1'b1, 16'hFFFF);
    queue_market(200, 100, 40, 50, 50);
    drain_quotes();

    idle_pct = 30;
    set_regs(16'd4, 31'd500, 24'd100, 1'b1, 1'b1, 16'd20);
    queue_market(300, 5000, 12, 600, 200);
    drain_quotes();

    idle_pct = 15;
    set_regs(16'd2, 31'd2000, 24'd7, 1'b0, 1'b1, 16'd5);
    queue_market(300, 30000, 4, 2500, 500);
    drain_quotes();

    // Final stretch runs at full rate on both sides
    idle_pct = 0;
    set_regs(16'd3, 31'd1000, 24'd9, 1'b1, 1'b0, 16'd300);
    queue_market(320, 100, 30, 1200, 300);
    drain_quotes();

    if (due_quotes.size() != 0)
      flag($sformatf("%0d results never arrived", due_quotes.size()));
    $display("Ran %0d items (%0d retires) under %0d register settings, %0d results checked",
             items_taken, retires_taken, settings_used, results_seen);
    $display("Actions seen: none %0d, place %0d, cancel %0d, replace %0d",
             act_seen[ActNone], act_seen[ActPlace], act_seen[ActCancel], act_seen[ActReplace]);
    if (err_count == 0) begin
      $display("tb_passive_quote_reconciler_top: clean");
    end else begin
      $display("tb_passive_quote_reconciler_top: errors");
    end
    $finish;
  end

endmodule

### passive_quote_reconciler_top.f
rtl/pqr_pkg.sv
rtl/pqr_front.sv
rtl/pqr_fifo.sv
rtl/pqr_back.sv
rtl/passive_quote_reconciler_top.sv
sim/tb_passive_quote_reconciler_top.sv
